### sv/ptpos_pkg.sv
// Package for the pulse tachometer with position count.
// Field widths, configuration register indexes and op codes.
// No dependencies.
package ptpos_pkg;

    localparam int ELAPSED_W = 32;
    localparam int SPEED_W   = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;
    localparam logic [CFG_W-1:0]     STALL_TO_RST  = 32'd1000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REVERSE_DIR   = 2'd0,
        CFG_BRAKE_ON      = 2'd1,
        CFG_STALL_TIMEOUT = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;

endpackage

### sv/pulse_tachometer_position.sv
// Pulse tachometer: elapsed tick count, signed position count and speed.
// Speed comes from a restoring divider, one quotient bit per cycle.
// Depends on ptpos_pkg.
//
//  channel   dir  handshake                 payload
//  s         in   i_s_tvalid / o_s_tready   i_s_tdata: op, pulse_seen
//  m         out  o_m_tvalid / i_m_tready   o_m_tdata: position_count, speed_rate,
//                                           pulse_taken
//  cfg       in   i_cfg_we                  i_cfg_idx, i_cfg_data
//
// An item that takes a pulse with a nonzero period below the stall timeout
// runs the divider in S_DIV for all SPEED_W (20) quotient bits, then goes to S_DONE.
// Any other item goes from S_IDLE straight to S_DONE.
// The next item is accepted once the result sits in the output register;
// a stalled output holds the block in its final step.
// Reset is synchronous; configuration returns to its reset values.
module pulse_tachometer_position
    import ptpos_pkg::*;
#(
    parameter int TICK_RATE   = 1000000,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,   // [0] op, [1] pulse_seen
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [55:0]          o_m_tdata,   // [31:0] position_count, [51:32] speed_rate,
                                              // [52] pulse_taken
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int                 CNT_W    = $clog2(SPEED_W);
    localparam logic [SPEED_W-1:0] RATE_VAL = SPEED_W'(TICK_RATE);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state                         r_state;
    logic                           r_reverse_dir;
    logic                           r_brake_on;
    logic [CFG_W-1:0]               r_stall_to;

    logic [ELAPSED_W-1:0]           r_elapsed;
    logic signed [COUNT_WIDTH-1:0]  r_pos;
    logic [SPEED_W-1:0]             r_speed;

    logic [ELAPSED_W-1:0]           r_period;
    logic                           r_taken;
    logic [ELAPSED_W-1:0]           r_rem;
    logic [SPEED_W-1:0]             r_dvd;
    logic [SPEED_W-1:0]             r_quot;
    logic [CNT_W-1:0]               r_cnt;

    logic                           r_out_valid;
    logic signed [COUNT_WIDTH-1:0]  r_out_pos;
    logic [SPEED_W-1:0]             r_out_speed;
    logic                           r_out_taken;

    logic                           in_fire;
    logic                           in_op;
    logic                           in_pulse;
    logic                           taken;
    logic                           stalled;
    logic signed [COUNT_WIDTH-1:0]  n_pos;
    logic [ELAPSED_W:0]             rem_sh;
    logic                           q_bit;
    logic [ELAPSED_W-1:0]           n_rem;
    logic                           out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign in_op      = i_s_tdata[0];
    assign in_pulse   = i_s_tdata[1];
    assign taken      = in_pulse && !r_brake_on;
    assign stalled    = (r_elapsed >= r_stall_to);
    assign out_free   = !r_out_valid || i_m_tready;

    always_comb begin
        n_pos = (t_op'(in_op) == OP_CLEAR) ? '0 : r_pos;
        if (taken) begin
            n_pos = r_reverse_dir ? n_pos - 1'b1 : n_pos + 1'b1;
        end
    end

    // one restoring divide step: next dividend bit in, trial subtract
    assign rem_sh = {r_rem, r_dvd[SPEED_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_period});
    assign n_rem  = q_bit ? ELAPSED_W'(rem_sh - {1'b0, r_period}) : rem_sh[ELAPSED_W-1:0];

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_taken, r_out_speed, 32'(r_out_pos)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_reverse_dir <= 1'b0;
            r_brake_on    <= 1'b0;
            r_stall_to    <= STALL_TO_RST;
            r_elapsed     <= '0;
            r_pos         <= '0;
            r_speed       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_REVERSE_DIR:   r_reverse_dir <= i_cfg_data[0];
                    CFG_BRAKE_ON:      r_brake_on    <= i_cfg_data[0];
                    CFG_STALL_TIMEOUT: r_stall_to    <= i_cfg_data;
                    default: ;
                endcase
            end

            // in S_DONE the output register is reloaded whenever it drains
            if (r_out_valid && i_m_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_pos    <= n_pos;
                        r_taken  <= taken;
                        r_period <= r_elapsed;
                        r_rem    <= '0;
                        r_dvd    <= RATE_VAL;
                        r_cnt    <= '0;
                        if (taken) begin
                            r_elapsed <= '0;
                        end else if (r_elapsed != ELAPSED_MAX) begin
                            r_elapsed <= r_elapsed + 1'b1;
                        end
                        if (stalled) begin
                            r_speed <= '0;
                            r_state <= S_DONE;
                        end else if (taken && r_elapsed == '0) begin
                            r_speed <= RATE_VAL;
                            r_state <= S_DONE;
                        end else if (taken) begin
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= n_rem;
                    r_dvd  <= {r_dvd[SPEED_W-2:0], 1'b0};
                    r_quot <= {r_quot[SPEED_W-2:0], q_bit};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(SPEED_W - 1)) begin
                        r_speed <= {r_quot[SPEED_W-2:0], q_bit};
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_pos   <= r_pos;
                        r_out_speed <= r_speed;
                        r_out_taken <= r_taken;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
